[hw/rtl/hca_pkg.sv]
package hca_pkg;

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_CH_W   = 6;
  localparam int unsigned CFG_SIDE_W = 10;

  // register reset values
  localparam logic [CFG_CH_W-1:0]   RST_CH_STORED = 6'd22;
  localparam logic [CFG_CH_W-1:0]   RST_CH_VALID  = 6'd22;
  localparam logic [CFG_SIDE_W-1:0] RST_MAP_WIDTH  = 10'd320;
  localparam logic [CFG_SIDE_W-1:0] RST_MAP_HEIGHT = 10'd320;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CH_STORED  = 2'd0,
    REG_CH_VALID   = 2'd1,
    REG_MAP_WIDTH  = 2'd2,
    REG_MAP_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_DRAIN = 2'd1,
    ST_EMIT  = 2'd2
  } seq_state_e;

  // control that travels with a memory read into the update stage
  typedef struct packed {
    logic smp;        // a sample word is in flight
    logic upd;        // its channel is searched
    logic seed;       // first position of the map
    logic emit;       // a result read is in flight
    logic emit_last;  // final result of the map
  } ctl_t;

endpackage

[hw/rtl/heatmap_channel_argmax.sv]
// channel   | dir | handshake            | payload
// sample    | in  | start_i / busy_o     | sample_i
// result    | out | strobe_o (one cycle) | channel_o, peak_x_o, peak_y_o, peak_value_o, last_o
// config    | in  | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// one sample word per cycle: a word is taken when start_i is high and busy_o low
// the per-channel peak table sits in one memory with a registered read; each word
// reads its channel entry, compares in the next cycle and writes back, with a
// bypass for the entry written at the same edge (single stored channel)
// after the last word of a map busy_o stays high through a drain state, which lets
// the final write land, then through an emit state with one memory read per result
// results leave on strobe_o through the read data register and the output register; the receiver cannot stall
// reset clears counters and state and loads the config defaults; the peak table is not cleared
module heatmap_channel_argmax #(
  parameter int unsigned MAX_CHANNELS = 32,
  parameter int unsigned MAX_SIDE     = 512,
  parameter int unsigned SAMPLE_BITS  = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // sample word
  input  logic                                        start_i,
  output logic                                        busy_o,
  input  logic signed [SAMPLE_BITS-1:0]               sample_i,
  // configuration writes
  input  logic                                        cfg_we_i,
  input  logic [hca_pkg::CFG_IDX_W-1:0]               cfg_idx_i,
  input  logic [hca_pkg::CFG_DATA_W-1:0]              cfg_wdata_i,
  // result words
  output logic                                        strobe_o,
  output logic [(MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1)-1:0] channel_o,
  output logic [$clog2(MAX_SIDE)-1:0]                 peak_x_o,
  output logic [$clog2(MAX_SIDE)-1:0]                 peak_y_o,
  output logic signed [SAMPLE_BITS-1:0]               peak_value_o,
  output logic                                        last_o
);
  import hca_pkg::*;

  localparam int unsigned CH_W  = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned XW    = $clog2(MAX_SIDE);
  localparam int unsigned ENT_W = SAMPLE_BITS + 2 * XW;

  // read issue side
  logic [CH_W-1:0] rd_addr;
  ctl_t            ctl_s0;
  logic [XW-1:0]   pos_x, pos_y;

  // compare stage, lines up with the memory read data
  ctl_t                          ctl_q;
  logic [CH_W-1:0]               ch_q;
  logic [XW-1:0]                 x_q, y_q;
  logic signed [SAMPLE_BITS-1:0] smp_q;

  // last write, for the same-edge read bypass
  logic             lw_vld_q;
  logic [CH_W-1:0]  lw_addr_q;
  logic [ENT_W-1:0] lw_data_q;

  logic [ENT_W-1:0]              rdata, cur, wdata;
  logic signed [SAMPLE_BITS-1:0] cur_val;
  logic                          we;

  // output register
  logic                          out_vld_q, out_last_q;
  logic [CH_W-1:0]               out_ch_q;
  logic [XW-1:0]                 out_x_q, out_y_q;
  logic signed [SAMPLE_BITS-1:0] out_val_q;

  hca_seq #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_SIDE     (MAX_SIDE)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_o      (busy_o),
    .rd_addr_o   (rd_addr),
    .ctl_o       (ctl_s0),
    .pos_x_o     (pos_x),
    .pos_y_o     (pos_y)
  );

  hca_peak_ram #(
    .DEPTH  (1 << CH_W),
    .DATA_W (ENT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ch_q),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_s0;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q  <= rd_addr;
    x_q   <= pos_x;
    y_q   <= pos_y;
    smp_q <= sample_i;
  end

  // entry as seen by this word: bypass the write that landed with the read
  assign cur     = (lw_vld_q && (lw_addr_q == ch_q)) ? lw_data_q : rdata;
  assign cur_val = cur[ENT_W-1 -: SAMPLE_BITS];

  // strictly greater wins, first position of the map always seeds
  assign we    = ctl_q.smp && ctl_q.upd && (ctl_q.seed || (smp_q > cur_val));
  assign wdata = {smp_q, x_q, y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_vld_q <= 1'b0;
    end else begin
      lw_vld_q <= we;
    end
  end

  always_ff @(posedge clk_i) begin
    lw_addr_q <= ch_q;
    lw_data_q <= wdata;
  end

  // result words come straight from the table, all writes have landed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      out_vld_q  <= ctl_q.emit;
      out_last_q <= ctl_q.emit && ctl_q.emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ch_q  <= ch_q;
    out_val_q <= rdata[ENT_W-1 -: SAMPLE_BITS];
    out_x_q   <= rdata[2*XW-1 -: XW];
    out_y_q   <= rdata[XW-1:0];
  end

  assign strobe_o     = out_vld_q;
  assign channel_o    = out_ch_q;
  assign peak_x_o     = out_x_q;
  assign peak_y_o     = out_y_q;
  assign peak_value_o = out_val_q;
  assign last_o       = out_last_q;

endmodule

[hw/rtl/hca_peak_ram.sv]
module hca_peak_ram #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned DATA_W = 34
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // read returns the old entry on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/hca_seq.sv]
module hca_seq #(
  parameter int unsigned MAX_CHANNELS = 32,
  parameter int unsigned MAX_SIDE     = 512
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic                                        cfg_we_i,
  input  logic [hca_pkg::CFG_IDX_W-1:0]               cfg_idx_i,
  input  logic [hca_pkg::CFG_DATA_W-1:0]              cfg_wdata_i,
  output logic                                        busy_o,
  output logic [(MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1)-1:0] rd_addr_o,
  output hca_pkg::ctl_t                               ctl_o,
  output logic [$clog2(MAX_SIDE)-1:0]                 pos_x_o,
  output logic [$clog2(MAX_SIDE)-1:0]                 pos_y_o
);
  import hca_pkg::*;

  localparam int unsigned CH_W   = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned XW     = $clog2(MAX_SIDE);
  localparam int unsigned CH_LW0 = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned CH_LW  = CH_LW0 > CFG_CH_W ? CH_LW0 : CFG_CH_W;
  localparam int unsigned SD_LW0 = $clog2(MAX_SIDE + 1);
  localparam int unsigned SD_LW  = SD_LW0 > CFG_SIDE_W ? SD_LW0 : CFG_SIDE_W;

  logic [CFG_CH_W-1:0]   ch_stored_q, ch_valid_q;
  logic [CFG_SIDE_W-1:0] map_width_q, map_height_q;

  logic [CH_W-1:0] ch_cnt_q, emit_idx_q;
  logic [XW-1:0]   col_cnt_q, row_cnt_q;

  seq_state_e state_q, state_d;

  logic [CH_LW-1:0] stored, valid, cs_ext, cv_ext, ch_next, emit_next;
  logic [SD_LW-1:0] width, height, w_ext, h_ext, col_next, row_next;
  logic             accept, end_ch, end_col, end_row, map_end, emit_last;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_stored_q  <= RST_CH_STORED;
      ch_valid_q   <= RST_CH_VALID;
      map_width_q  <= RST_MAP_WIDTH;
      map_height_q <= RST_MAP_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CH_STORED:  ch_stored_q  <= cfg_wdata_i[CFG_CH_W-1:0];
        REG_CH_VALID:   ch_valid_q   <= cfg_wdata_i[CFG_CH_W-1:0];
        REG_MAP_WIDTH:  map_width_q  <= cfg_wdata_i[CFG_SIDE_W-1:0];
        REG_MAP_HEIGHT: map_height_q <= cfg_wdata_i[CFG_SIDE_W-1:0];
      endcase
    end
  end

  // clamped limits
  always_comb begin
    cs_ext = CH_LW'(ch_stored_q);
    cv_ext = CH_LW'(ch_valid_q);
    w_ext  = SD_LW'(map_width_q);
    h_ext  = SD_LW'(map_height_q);
    if (cs_ext == '0) begin
      stored = CH_LW'(1);
    end else if (cs_ext > CH_LW'(MAX_CHANNELS)) begin
      stored = CH_LW'(MAX_CHANNELS);
    end else begin
      stored = cs_ext;
    end
    if (cv_ext == '0) begin
      valid = CH_LW'(1);
    end else if (cv_ext > stored) begin
      valid = stored;
    end else begin
      valid = cv_ext;
    end
    if (w_ext == '0) begin
      width = SD_LW'(1);
    end else if (w_ext > SD_LW'(MAX_SIDE)) begin
      width = SD_LW'(MAX_SIDE);
    end else begin
      width = w_ext;
    end
    if (h_ext == '0) begin
      height = SD_LW'(1);
    end else if (h_ext > SD_LW'(MAX_SIDE)) begin
      height = SD_LW'(MAX_SIDE);
    end else begin
      height = h_ext;
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign accept    = start_i && !busy_o;
  assign ch_next   = CH_LW'(ch_cnt_q) + CH_LW'(1);
  assign col_next  = SD_LW'(col_cnt_q) + SD_LW'(1);
  assign row_next  = SD_LW'(row_cnt_q) + SD_LW'(1);
  assign emit_next = CH_LW'(emit_idx_q) + CH_LW'(1);
  assign end_ch    = ch_next >= stored;
  assign end_col   = col_next >= width;
  assign end_row   = row_next >= height;
  assign map_end   = accept && end_ch && end_col && end_row;
  assign emit_last = emit_next >= valid;

  // position counters, channel fastest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_cnt_q  <= '0;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (accept) begin
      if (!end_ch) begin
        ch_cnt_q <= ch_next[CH_W-1:0];
      end else begin
        ch_cnt_q <= '0;
        if (!end_col) begin
          col_cnt_q <= col_next[XW-1:0];
        end else begin
          col_cnt_q <= '0;
          if (!end_row) begin
            row_cnt_q <= row_next[XW-1:0];
          end else begin
            row_cnt_q <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      emit_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DRAIN) begin
        emit_idx_q <= '0;
      end else if (state_q == ST_EMIT) begin
        emit_idx_q <= emit_next[CH_W-1:0];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (map_end) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT:  if (emit_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o     = '0;
    rd_addr_o = ch_cnt_q;
    pos_x_o   = col_cnt_q;
    pos_y_o   = row_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        ctl_o.smp  = accept;
        ctl_o.upd  = CH_LW'(ch_cnt_q) < valid;
        ctl_o.seed = (col_cnt_q == '0) && (row_cnt_q == '0);
      end
      ST_DRAIN: begin
        ctl_o = '0;
      end
      ST_EMIT: begin
        rd_addr_o       = emit_idx_q;
        ctl_o.emit      = 1'b1;
        ctl_o.emit_last = emit_last;
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

endmodule
